@@ sv/pfd_pkg.sv @@
package pfd_pkg;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_LETTER = 2'd1;
	localparam logic [1:0] CMD_END = 2'd2;

	localparam logic REG_PAD = 1'b0;
	localparam logic REG_SKIP = 1'b1;

	localparam logic [7:0] PAD_RESET = 8'h58;
	localparam logic [7:0] SKIP_RESET = 8'h20;

	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam int OP_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PAIR = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [4:0] idx;
		logic [7:0] a;
		logic [7:0] b;
	} op_t;

	typedef struct packed {
		logic [7:0] sym;
		logic second;
		logic nf;
	} res_t;

endpackage

@@ sv/pfd_ram.sv @@
module pfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 25
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first: a read and a write to the same address return old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/pfd_fifo.sv @@
module pfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	input logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty,
	output logic full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign empty = (count_q == '0);
	assign full = (count_q == CW'(DEPTH));
	assign count = count_q;
	assign rdata = buf_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wptr_q] <= wdata;
		end
	end

endmodule

@@ sv/pfd_front.sv @@
module pfd_front #(
	parameter int SQUARE_SIDE = 5
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [1:0] cmd,
	input logic [4:0] cell_index,
	input logic [7:0] symbol,
	input logic cfg_we,
	input logic cfg_index,
	input logic [7:0] cfg_data,
	output logic op_valid,
	output pfd_pkg::op_t op
);

	localparam int CELLS = SQUARE_SIDE * SQUARE_SIDE;

	logic [7:0] pad_q;
	logic [7:0] skip_q;
	logic [7:0] held_q;
	logic held_valid_q;
	logic [7:0] held_d;
	logic held_valid_d;
	logic [7:0] letter;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= pfd_pkg::PAD_RESET;
			skip_q <= pfd_pkg::SKIP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pfd_pkg::REG_PAD: pad_q <= cfg_data;
				pfd_pkg::REG_SKIP: skip_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		letter = symbol;
		if (symbol inside {[pfd_pkg::LOWER_A:pfd_pkg::LOWER_Z]}) begin
			letter = symbol - pfd_pkg::CASE_OFFSET;
		end
	end

	always_comb begin
		op_valid = 1'b0;
		op.kind = pfd_pkg::OP_LOAD;
		op.idx = cell_index;
		op.a = symbol;
		op.b = pad_q;
		held_d = held_q;
		held_valid_d = held_valid_q;
		if (accept) begin
			case (cmd)
				pfd_pkg::CMD_LOAD: begin
					op_valid = (32'(cell_index) < CELLS);
				end
				pfd_pkg::CMD_LETTER: begin
					if (symbol != skip_q) begin
						if (!held_valid_q) begin
							held_d = letter;
							held_valid_d = 1'b1;
						end else begin
							op_valid = 1'b1;
							op.kind = pfd_pkg::OP_PAIR;
							op.a = held_q;
							if (letter != held_q) begin
								op.b = letter;
								held_d = '0;
								held_valid_d = 1'b0;
							end
						end
					end
				end
				pfd_pkg::CMD_END: begin
					if (held_valid_q) begin
						op_valid = 1'b1;
						op.kind = pfd_pkg::OP_PAIR;
						op.a = held_q;
						held_d = '0;
						held_valid_d = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			held_valid_q <= 1'b0;
		end else begin
			held_q <= held_d;
			held_valid_q <= held_valid_d;
		end
	end

endmodule

@@ sv/pfd_back.sv @@
module pfd_back #(
	parameter int SQUARE_SIDE = 5
) (
	input logic clk,
	input logic arst_n,
	input logic op_empty,
	input pfd_pkg::op_t op,
	output logic op_pop,
	input logic [$clog2(pfd_pkg::OUT_DEPTH+1)-1:0] out_count,
	output logic res_valid,
	output pfd_pkg::res_t res
);

	localparam int CELLS = SQUARE_SIDE * SQUARE_SIDE;
	localparam int AW = $clog2(CELLS);
	localparam int RW = $clog2(SQUARE_SIDE);

	logic [7:0] cells_q [CELLS];

	logic fa;
	logic fb;
	logic [RW-1:0] ra;
	logic [RW-1:0] ca;
	logic [RW-1:0] rb;
	logic [RW-1:0] cb;

	logic valid_s1;
	logic step_s1;
	logic ok_s1;
	logic [RW-1:0] ra_s1;
	logic [RW-1:0] ca_s1;
	logic [RW-1:0] rb_s1;
	logic [RW-1:0] cb_s1;

	logic valid_s2;
	logic second_s2;
	logic nf_s2;

	logic issue;
	logic load_we;
	logic [AW-1:0] load_addr;
	logic [RW-1:0] sel_r;
	logic [RW-1:0] sel_c;
	logic [AW-1:0] rd_addr;
	logic [7:0] rd_data;

	function automatic logic [RW-1:0] wrap_inc(input logic [RW-1:0] v);
		wrap_inc = (v == RW'(SQUARE_SIDE-1)) ? '0 : v + 1'b1;
	endfunction

	// first match in row-major order
	always_comb begin
		fa = 1'b0;
		fb = 1'b0;
		ra = '0;
		ca = '0;
		rb = '0;
		cb = '0;
		for (int r = 0; r < SQUARE_SIDE; r++) begin
			for (int c = 0; c < SQUARE_SIDE; c++) begin
				if (!fa && cells_q[r*SQUARE_SIDE+c] == op.a) begin
					fa = 1'b1;
					ra = RW'(r);
					ca = RW'(c);
				end
				if (!fb && cells_q[r*SQUARE_SIDE+c] == op.b) begin
					fb = 1'b1;
					rb = RW'(r);
					cb = RW'(c);
				end
			end
		end
	end

	assign issue = valid_s1 &&
		((32'(out_count) + 32'(valid_s2)) < pfd_pkg::OUT_DEPTH);
	assign op_pop = !op_empty && (!valid_s1 || (issue && step_s1));
	assign load_we = op_pop && (op.kind == pfd_pkg::OP_LOAD);
	assign load_addr = AW'(op.idx);

	always_ff @(posedge clk) begin
		if (load_we) begin
			cells_q[load_addr] <= op.a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_s1 <= 1'b0;
		end else if (op_pop) begin
			valid_s1 <= (op.kind == pfd_pkg::OP_PAIR);
			step_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= !step_s1;
			step_s1 <= !step_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			ok_s1 <= fa && fb;
			ra_s1 <= ra;
			ca_s1 <= ca;
			rb_s1 <= rb;
			cb_s1 <= cb;
		end
	end

	always_comb begin
		if (ra_s1 == rb_s1) begin
			sel_r = step_s1 ? rb_s1 : ra_s1;
			sel_c = step_s1 ? wrap_inc(cb_s1) : wrap_inc(ca_s1);
		end else if (ca_s1 == cb_s1) begin
			sel_r = step_s1 ? wrap_inc(rb_s1) : wrap_inc(ra_s1);
			sel_c = step_s1 ? cb_s1 : ca_s1;
		end else begin
			sel_r = step_s1 ? rb_s1 : ra_s1;
			sel_c = step_s1 ? ca_s1 : cb_s1;
		end
		rd_addr = AW'(32'(sel_r) * SQUARE_SIDE + 32'(sel_c));
	end

	pfd_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_square (
		.clk(clk),
		.we(load_we),
		.waddr(load_addr),
		.wdata(op.a),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			second_s2 <= step_s1;
			nf_s2 <= !ok_s1;
		end
	end

	assign res_valid = valid_s2;
	assign res.sym = nf_s2 ? 8'h00 : rd_data;
	assign res.second = second_s2;
	assign res.nf = nf_s2;

endmodule

@@ sv/playfair_digraph_encryptor.sv @@
// Playfair digraph encryptor. Items enter through a queue-style port (push/full) and
// results leave through one (empty/pop). cmd 0 loads one square cell, cmd 1 feeds a
// plaintext letter, cmd 2 ends the text and pads a held odd letter. A new item is
// taken every cycle until the 4-entry command queue fills. One square RAM read is made
// per ciphertext byte, the two bytes of a pair in turn, so results stream at one per
// cycle while the output queue has room; each byte passes the command queue, stage 1
// and the registered square read. The square powers up unknown and has no clearing
// pass: load every cell before sending letters. Registers: index 0 pad symbol
// (reset 'X'), index 1 skip symbol (reset space); write them only while idle.
module playfair_digraph_encryptor #(
	parameter int SQUARE_SIDE = 5
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] cmd,
	input logic [4:0] cell_index,
	input logic [7:0] symbol,
	output logic empty,
	input logic pop,
	output logic [7:0] out_symbol,
	output logic second_of_pair,
	output logic not_found,
	input logic cfg_we,
	input logic cfg_index,
	input logic [7:0] cfg_data
);

	localparam int OPW = $bits(pfd_pkg::op_t);
	localparam int RESW = $bits(pfd_pkg::res_t);

	logic accept;
	logic op_valid;
	pfd_pkg::op_t op_in;
	pfd_pkg::op_t op_head;
	logic op_empty;
	logic op_pop;
	logic res_valid;
	pfd_pkg::res_t res_in;
	pfd_pkg::res_t res_head;
	logic [$clog2(pfd_pkg::OUT_DEPTH+1)-1:0] out_count;

	assign accept = push && !full;

	pfd_front #(
		.SQUARE_SIDE(SQUARE_SIDE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd(cmd),
		.cell_index(cell_index),
		.symbol(symbol),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.op_valid(op_valid),
		.op(op_in)
	);

	pfd_fifo #(
		.WIDTH(OPW),
		.DEPTH(pfd_pkg::OP_DEPTH)
	) u_op_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(op_valid),
		.wdata(op_in),
		.pop(op_pop),
		.rdata(op_head),
		.empty(op_empty),
		.full(full),
		.count()
	);

	pfd_back #(
		.SQUARE_SIDE(SQUARE_SIDE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op_empty(op_empty),
		.op(op_head),
		.op_pop(op_pop),
		.out_count(out_count),
		.res_valid(res_valid),
		.res(res_in)
	);

	pfd_fifo #(
		.WIDTH(RESW),
		.DEPTH(pfd_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.wdata(res_in),
		.pop(pop),
		.rdata(res_head),
		.empty(empty),
		.full(),
		.count(out_count)
	);

	assign out_symbol = res_head.sym;
	assign second_of_pair = res_head.second;
	assign not_found = res_head.nf;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int SIDE = 5;
	localparam int CELLS = SIDE * SIDE;
	localparam int SETTLE = 16;
	localparam int HOLD_CYCLES = 250;
	localparam int STALL_LIMIT = 4000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [1:0] cmd;
	logic [4:0] cell_index;
	logic [7:0] symbol;
	logic empty;
	logic pop;
	logic [7:0] out_symbol;
	logic second_of_pair;
	logic not_found;
	logic cfg_we;
	logic cfg_index;
	logic [7:0] cfg_data;

	logic [7:0] sq_model [CELLS];
	logic [7:0] held_ltr;
	bit held_on;
	logic [7:0] pad_reg;
	logic [7:0] skip_reg;
	pfd_pkg::res_t cipher_q [$];

	bit tx_idle_en;
	bit rx_idle_en;
	bit hold_req;
	int n_items;
	int n_results;
	int n_writes;
	int n_squares;
	int errors;

	playfair_digraph_encryptor #(
		.SQUARE_SIDE(SIDE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.cell_index(cell_index),
		.symbol(symbol),
		.empty(empty),
		.pop(pop),
		.out_symbol(out_symbol),
		.second_of_pair(second_of_pair),
		.not_found(not_found),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit locate_cell(input logic [7:0] ltr, output int row, output int col);
		bit hit;
		hit = 1'b0;
		row = 0;
		col = 0;
		for (int i = 0; i < CELLS; i++) begin
			if (!hit && sq_model[i] == ltr) begin
				hit = 1'b1;
				row = i / SIDE;
				col = i % SIDE;
			end
		end
		return hit;
	endfunction

	function automatic void expect_cipher(input logic [7:0] a, input logic [7:0] b);
		int r1, c1, r2, c2;
		bit ok1, ok2;
		pfd_pkg::res_t x, y;
		ok1 = locate_cell(a, r1, c1);
		ok2 = locate_cell(b, r2, c2);
		x.second = 1'b0;
		y.second = 1'b1;
		x.nf = !(ok1 && ok2);
		y.nf = x.nf;
		if (x.nf) begin
			x.sym = 8'h00;
			y.sym = 8'h00;
		end else if (r1 == r2) begin
			x.sym = sq_model[r1 * SIDE + (c1 + 1) % SIDE];
			y.sym = sq_model[r2 * SIDE + (c2 + 1) % SIDE];
		end else if (c1 == c2) begin
			x.sym = sq_model[((r1 + 1) % SIDE) * SIDE + c1];
			y.sym = sq_model[((r2 + 1) % SIDE) * SIDE + c2];
		end else begin
			x.sym = sq_model[r1 * SIDE + c2];
			y.sym = sq_model[r2 * SIDE + c1];
		end
		cipher_q.push_back(x);
		cipher_q.push_back(y);
	endfunction

	function automatic void predict_item(input logic [1:0] c, input logic [4:0] idx,
			input logic [7:0] s);
		logic [7:0] ltr;
		ltr = s;
		case (c)
			pfd_pkg::CMD_LOAD: begin
				if (idx < CELLS)
					sq_model[idx] = s;
			end
			pfd_pkg::CMD_LETTER: begin
				if (s != skip_reg) begin
					if (ltr >= pfd_pkg::LOWER_A && ltr <= pfd_pkg::LOWER_Z)
						ltr = ltr - pfd_pkg::CASE_OFFSET;
					if (!held_on) begin
						held_ltr = ltr;
						held_on = 1'b1;
					end else if (ltr == held_ltr) begin
						expect_cipher(held_ltr, pad_reg);
					end else begin
						expect_cipher(held_ltr, ltr);
						held_on = 1'b0;
						held_ltr = 8'h00;
					end
				end
			end
			pfd_pkg::CMD_END: begin
				if (held_on) begin
					expect_cipher(held_ltr, pad_reg);
					held_on = 1'b0;
					held_ltr = 8'h00;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < 40)
			$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic send_item(input logic [1:0] c, input logic [4:0] idx, input logic [7:0] s);
		push <= 1'b1;
		cmd <= c;
		cell_index <= idx;
		symbol <= s;
		do @(posedge clk); while (full);
		predict_item(c, idx, s);
		n_items++;
	endtask

	task automatic sender_gap();
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic send_letter(input logic [7:0] s);
		send_item(pfd_pkg::CMD_LETTER, 5'($urandom_range(0, 31)), s);
		sender_gap();
	endtask

	task automatic send_end();
		send_item(pfd_pkg::CMD_END, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
		sender_gap();
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pfd_pkg::REG_PAD)
			pad_reg = data;
		else
			skip_reg = data;
		n_writes++;
	endtask

	// mode 0: classic keyed square in order, 1: shuffled alphabet, 2: shuffled alphabet with random bytes in some cells
	task automatic load_square(input int mode);
		string keysq;
		logic [7:0] vals [26];
		int order [CELLS];
		int j, tmp;
		logic [7:0] tv;
		keysq = "PLAYFIREXMBCDGHKNOQSTUVWZ";
		for (int i = 0; i < 26; i++)
			vals[i] = (mode == 0 && i < CELLS) ? keysq[i] : 8'("A" + i);
		if (mode != 0) begin
			for (int i = 25; i > 0; i--) begin
				j = $urandom_range(0, i);
				tv = vals[i];
				vals[i] = vals[j];
				vals[j] = tv;
			end
		end
		if (mode == 2) begin
			for (int i = 0; i < CELLS; i++)
				if ($urandom_range(0, 2) == 0)
					vals[i] = 8'($urandom_range(0, 255));
		end
		for (int i = 0; i < CELLS; i++)
			order[i] = i;
		if (mode != 0) begin
			for (int i = CELLS - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
		end
		for (int i = 0; i < CELLS; i++) begin
			send_item(pfd_pkg::CMD_LOAD, 5'(order[i]), vals[order[i]]);
			sender_gap();
		end
		n_squares++;
	endtask

	function automatic logic [7:0] pick_letter();
		int k;
		logic [7:0] s;
		k = $urandom_range(0, 99);
		s = sq_model[$urandom_range(0, CELLS - 1)];
		if (k < 65)
			return s;
		if (k < 75)
			return (s >= "A" && s <= "Z") ? s + pfd_pkg::CASE_OFFSET : s;
		if (k < 80)
			return skip_reg;
		if (k < 87)
			return pad_reg;
		if (k < 92)
			return held_on ? held_ltr : s;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_random_item();
		int k;
		k = $urandom_range(0, 99);
		if (k < 80) begin
			send_letter(pick_letter());
		end else if (k < 90) begin
			send_end();
		end else if (k < 95) begin
			send_item(pfd_pkg::CMD_LOAD, 5'($urandom_range(0, 31)),
				8'($urandom_range(0, 255)));
			sender_gap();
		end else begin
			send_item(CMD_UNUSED, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
			sender_gap();
		end
	endtask

	task automatic test_classic_rules();
		load_square(0);
		send_letter("P"); send_letter("L");
		send_letter("P"); send_letter("I");
		send_letter("F"); send_letter("P");
		send_letter("T"); send_letter("P");
		send_letter("h"); send_letter(" "); send_letter("E");
		send_letter("E"); send_letter("E");
		send_end();
		send_letter("X"); send_letter("X");
		send_end();
		send_end();
	endtask

	task automatic test_edge_items();
		send_letter(8'h00); send_letter(8'hFF);
		send_letter("1"); send_letter("P");
		send_item(pfd_pkg::CMD_LOAD, 5'd31, 8'hFF); sender_gap();
		send_item(pfd_pkg::CMD_LOAD, 5'd25, 8'h00); sender_gap();
		send_item(CMD_UNUSED, 5'd31, 8'hFF); sender_gap();
		send_item(CMD_UNUSED, 5'd0, 8'h00); sender_gap();
		send_letter("A");
		send_item(pfd_pkg::CMD_LOAD, 5'd24, "*"); sender_gap();
		send_letter("W");
		send_item(pfd_pkg::CMD_LOAD, 5'd24, "Z"); sender_gap();
		send_end();
	endtask

	task automatic test_register_extremes();
		logic [7:0] pads [5];
		logic [7:0] skips [5];
		pads = '{8'h00, 8'hFF, "Q", "j", pfd_pkg::PAD_RESET};
		skips = '{8'hFF, 8'h00, "a", "Q", pfd_pkg::SKIP_RESET};
		for (int p = 0; p < 5; p++) begin
			if (p == 2 || p == 4)
				load_square(1);
			else if (p == 3)
				load_square(2);
			write_reg(pfd_pkg::REG_PAD, pads[p]);
			write_reg(pfd_pkg::REG_SKIP, skips[p]);
			if (p == 2) begin
				send_letter("a"); send_letter("A"); send_letter("Q");
			end
			repeat (15) send_random_item();
		end
	endtask

	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		hold_req = 1'b1;
		repeat (40) send_item(pfd_pkg::CMD_LETTER, 5'd0, pick_letter());
		push <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		tx_idle_en = 1'b1;
	endtask

	task automatic test_random_mix();
		for (int n = 0; n < 80; n++) begin
			if (n == 30)
				load_square(2);
			if (n == 60) begin
				load_square(1);
				write_reg(pfd_pkg::REG_PAD, 8'($urandom_range(0, 255)));
				write_reg(pfd_pkg::REG_SKIP, 8'($urandom_range(0, 255)));
			end
			send_random_item();
		end
	endtask

	task automatic test_streaming();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_reg(pfd_pkg::REG_PAD, pfd_pkg::PAD_RESET);
		write_reg(pfd_pkg::REG_SKIP, pfd_pkg::SKIP_RESET);
		repeat (60) send_random_item();
	endtask

	always @(posedge clk) begin
		pfd_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			n_results++;
			if (cipher_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", out_symbol));
			end else begin
				want = cipher_q.pop_front();
				if (out_symbol !== want.sym)
					report_mismatch($sformatf("out_symbol %02h, want %02h",
						out_symbol, want.sym));
				if (second_of_pair !== want.second)
					report_mismatch($sformatf("second_of_pair %b, want %b",
						second_of_pair, want.second));
				if (not_found !== want.nf)
					report_mismatch($sformatf("not_found %b, want %b",
						not_found, want.nf));
			end
		end
	end

	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall = 0;
			else
				stall++;
			if (stall >= STALL_LIMIT)
				break;
		end
		$display("FAIL playfair_digraph_encryptor");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		cmd <= pfd_pkg::CMD_LOAD;
		cell_index <= 5'd0;
		symbol <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= pfd_pkg::REG_PAD;
		cfg_data <= 8'h00;
		for (int i = 0; i < CELLS; i++)
			sq_model[i] = 8'h00;
		held_ltr = 8'h00;
		held_on = 1'b0;
		pad_reg = pfd_pkg::PAD_RESET;
		skip_reg = pfd_pkg::SKIP_RESET;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_classic_rules();
		test_edge_items();
		test_register_extremes();
		test_backpressure();
		test_random_mix();
		test_streaming();

		push <= 1'b0;
		while (cipher_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (cipher_q.size() != 0)
			report_mismatch($sformatf("%0d bytes never came", cipher_q.size()));
		$display("run: %0d items, %0d ciphertext bytes checked, %0d register writes",
			n_items, n_results, n_writes);
		$display("run: %0d squares loaded, %0d mismatches", n_squares, errors);
		if (errors == 0)
			$display("PASS playfair_digraph_encryptor");
		else
			$display("FAIL playfair_digraph_encryptor");
		$finish;
	end

endmodule
